>>> rtl/cph_pkg.sv
// Shared constants, pipeline item type and helper functions for the hemisphere mapper.
package cph_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SAMPLE_BITS_MAX = 24;

   localparam int CORDIC_STEPS = 16;
   localparam int LOG_FRAC     = 24;
   localparam int DIV_STEPS    = 30;
   localparam int EXP_STEPS    = 24;
   localparam int SQRT_STEPS   = 31;

   // stage map of the cell row
   localparam int ST_PREP   = LOG_FRAC;
   localparam int ST_DIV0   = ST_PREP + 1;
   localparam int ST_EXP0   = ST_DIV0 + DIV_STEPS;
   localparam int ST_SHIFT  = ST_EXP0 + EXP_STEPS;
   localparam int ST_SQUARE = ST_SHIFT + 1;
   localparam int ST_SQRT0  = ST_SQUARE + 1;
   localparam int ST_MULU   = ST_SQRT0 + SQRT_STEPS;
   localparam int ST_MULV   = ST_MULU + 1;
   localparam int ST_ROUND  = ST_MULV + 1;
   localparam int NUM_CELLS = ST_ROUND + 1;

   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [33:0] CORDIC_GAIN = 34'h0_26DD_3B6A;
   localparam logic [14:0] W_MAX      = 15'd32767;

   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic [1:0]         q;
      logic               one;
      logic [30:0]        m;
      logic [23:0]        frac;
      logic [4:0]         p;
      logic [37:0]        num;
      logic [16:0]        rem;
      logic [29:0]        quo;
      logic [30:0]        r;
      logic [30:0]        ct;
      logic [60:0]        rad;
      logic [61:0]        res;
      logic [63:0]        pu;
      logic [63:0]        pv;
      logic               negu;
      logic               negv;
      logic signed [15:0] du;
      logic signed [15:0] dv;
      logic [14:0]        w15;
   } item_type;

   // c_k = 2^(-2^-k) in Q30, evaluated at elaboration
   function automatic logic [29:0] exp_coef(input int k);
      logic [63:0] c;
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] b;
      c = 64'd1 << 29;
      for (int i = 1; i <= k; i++) begin
         n   = c << 30;
         res = '0;
         b   = 64'd1 << 62;
         for (int j = 0; j < 32; j++) begin
            if (n >= res + b) begin
               n   = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         c = res;
      end
      return c[29:0];
   endfunction

   // Q60 product magnitude to saturated Q15
   function automatic logic signed [15:0] scale_q15(input logic [63:0] prod, input logic neg);
      logic [64:0] sum;
      logic [19:0] r;
      logic signed [15:0] val;
      sum = {1'b0, prod} + (65'd1 << 44);
      r   = sum[64:45];
      if (neg) begin
         if (r > 20'd32768) val = -16'sd32768;
         else val = 16'(-$signed({1'b0, r}));
      end else begin
         if (r > 20'd32767) val = 16'sd32767;
         else val = $signed(r[15:0]);
      end
      return val;
   endfunction

endpackage

>>> rtl/cph_cell.sv
// One pipeline cell: a registered step of the mapper, chosen by its position in the row.
module cph_cell import cph_pkg::*; #(
   parameter int STAGE       = 0,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] cosine_exponent,
   input  logic        up_valid,
   input  item_type    up_item,
   output logic        up_ready,
   output logic        dn_valid,
   output item_type    dn_item,
   input  logic        dn_ready
);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   generate
      if (STAGE < LOG_FRAC) begin : g_log
         localparam int CI = STAGE % CORDIC_STEPS;
         logic [61:0]        sq;
         logic signed [33:0] dx;
         logic signed [33:0] dy;
         logic signed [33:0] at;
         always_comb begin
            item_in = up_item;
            // log2 fraction bit by squaring
            sq = 62'(up_item.m) * 62'(up_item.m);
            if (sq[61]) begin
               item_in.m    = sq[61:31];
               item_in.frac = {up_item.frac[22:0], 1'b1};
            end else begin
               item_in.m    = sq[60:30];
               item_in.frac = {up_item.frac[22:0], 1'b0};
            end
            dx = up_item.y >>> CI;
            dy = up_item.x >>> CI;
            at = $signed({2'b00, ATAN_TURN[CI]});
            if (STAGE < CORDIC_STEPS) begin
               if (!up_item.z[33]) begin
                  item_in.x = up_item.x - dx;
                  item_in.y = up_item.y + dy;
                  item_in.z = up_item.z - at;
               end else begin
                  item_in.x = up_item.x + dx;
                  item_in.y = up_item.y - dy;
                  item_in.z = up_item.z + at;
               end
            end
         end
      end else if (STAGE == ST_PREP) begin : g_prep
         logic [28:0] nl;
         logic [16:0] d;
         logic [37:0] numer;
         always_comb begin
            item_in = up_item;
            nl    = (29'(SAMPLE_BITS - 32'(up_item.p)) << LOG_FRAC) - 29'(up_item.frac);
            d     = 17'(cosine_exponent) + 17'd256;
            numer = {1'b0, nl, 8'd0} + 38'(d >> 1);
            item_in.num = numer;
            item_in.rem = 17'(numer[37:30]);
            item_in.quo = '0;
            item_in.r   = ONE_Q30;
            // fold the nearest quadrant back in
            case (up_item.q)
               2'd0: begin item_in.x = up_item.x;  item_in.y = up_item.y;  end
               2'd1: begin item_in.x = -up_item.y; item_in.y = up_item.x;  end
               2'd2: begin item_in.x = -up_item.x; item_in.y = -up_item.y; end
               default: begin item_in.x = up_item.y; item_in.y = -up_item.x; end
            endcase
         end
      end else if (STAGE < ST_EXP0) begin : g_div
         localparam int DB = ST_EXP0 - 1 - STAGE;
         logic [17:0] sh;
         logic [16:0] d;
         always_comb begin
            item_in = up_item;
            d  = 17'(cosine_exponent) + 17'd256;
            sh = {up_item.rem, up_item.num[DB]};
            if (sh >= {1'b0, d}) begin
               item_in.rem     = 17'(sh - {1'b0, d});
               item_in.quo[DB] = 1'b1;
            end else begin
               item_in.rem = sh[16:0];
            end
         end
      end else if (STAGE < ST_SHIFT) begin : g_exp
         localparam int K = STAGE - ST_EXP0 + 1;
         localparam logic [29:0] COEF = exp_coef(K);
         logic [61:0] prod;
         always_comb begin
            item_in = up_item;
            prod = 62'(up_item.r) * 62'(COEF) + (62'd1 << 29);
            if (up_item.quo[LOG_FRAC - K]) begin
               item_in.r = prod[60:30];
            end
         end
      end else if (STAGE == ST_SHIFT) begin : g_shift
         logic [5:0]  n;
         logic [30:0] c;
         always_comb begin
            item_in = up_item;
            n = up_item.quo[29:24];
            if (n >= 6'd31) c = '0;
            else c = up_item.r >> n;
            if (up_item.one || c > ONE_Q30) c = ONE_Q30;
            item_in.ct = c;
         end
      end else if (STAGE == ST_SQUARE) begin : g_square
         logic [61:0] sq;
         logic [15:0] wr;
         always_comb begin
            item_in = up_item;
            sq = 62'(up_item.ct) * 62'(up_item.ct);
            item_in.rad = 61'((62'd1 << 60) - sq);
            item_in.res = '0;
            wr = 16'((up_item.ct + 31'd16384) >> 15);
            item_in.w15 = (wr > 16'(W_MAX)) ? W_MAX : wr[14:0];
         end
      end else if (STAGE < ST_MULU) begin : g_sqrt
         localparam int BP = 60 - 2 * (STAGE - ST_SQRT0);
         logic [61:0] b;
         logic [61:0] t;
         always_comb begin
            item_in = up_item;
            b = 62'd1 << BP;
            t = up_item.res + b;
            if ({1'b0, up_item.rad} >= t) begin
               item_in.rad = 61'({1'b0, up_item.rad} - t);
               item_in.res = (up_item.res >> 1) + b;
            end else begin
               item_in.res = up_item.res >> 1;
            end
         end
      end else if (STAGE == ST_MULU) begin : g_mulu
         logic [32:0] mag;
         always_comb begin
            item_in = up_item;
            mag = up_item.x[33] ? 33'(-up_item.x) : up_item.x[32:0];
            item_in.negu = up_item.x[33];
            item_in.pu   = 64'(up_item.res[30:0]) * 64'(mag);
         end
      end else if (STAGE == ST_MULV) begin : g_mulv
         logic [32:0] mag;
         always_comb begin
            item_in = up_item;
            mag = up_item.y[33] ? 33'(-up_item.y) : up_item.y[32:0];
            item_in.negv = up_item.y[33];
            item_in.pv   = 64'(up_item.res[30:0]) * 64'(mag);
         end
      end else begin : g_round
         always_comb begin
            item_in = up_item;
            item_in.du = scale_q15(up_item.pu, up_item.negu);
            item_in.dv = scale_q15(up_item.pv, up_item.negv);
         end
      end
   endgenerate

endmodule

>>> rtl/cosine_power_hemisphere_map.sv
// Top level: unit-square sample to cosine-power hemisphere direction, row of pipeline cells.
//
//   channel | ports                               | direction
//   request | req_valid/ready, req_sample_u/v     | in
//   result  | rsp_valid/ready, rsp_dir_u/v/w      | out
//   csr     | csr_wr_en, csr_wr_data              | in
//
// One request per cycle while rsp_ready is high; the cell row holds 24 log
// squaring cells, 30 divider cells, 24 exp cells and 31 square-root cells.
// Each cell holds one request; a stall fills bubbles before the input stops.
// Reset clears the cell valid bits and sets the exponent to zero.
module cosine_power_hemisphere_map import cph_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_u,
   input  logic [SAMPLE_BITS-1:0] req_sample_v,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_dir_u,
   output logic signed [15:0]     rsp_dir_v,
   output logic [14:0]            rsp_dir_w
);

   logic [15:0] exponent_ff;
   item_type    entry;
   logic [NUM_CELLS:0] vld;
   logic [NUM_CELLS:0] rdy;
   item_type           itm [NUM_CELLS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= '0;
      end else if (csr_wr_en) begin
         exponent_ff <= csr_wr_data;
      end
   end

   logic [31:0] ang;
   logic [31:0] ang_r;
   logic [1:0]  quad;
   logic [24:0] wv;
   logic [4:0]  msb;

   always_comb begin
      entry = '0;
      ang   = 32'(req_sample_u) << (32 - SAMPLE_BITS);
      quad  = 2'((ang + 32'h2000_0000) >> 30);
      ang_r = ang - (32'(quad) << 30);
      wv    = (25'd1 << SAMPLE_BITS) - 25'(req_sample_v);
      msb   = '0;
      for (int i = 0; i < SAMPLE_BITS_MAX; i++) begin
         if (wv[i]) msb = 5'(i);
      end
      entry.x   = $signed(CORDIC_GAIN);
      entry.y   = '0;
      entry.z   = 34'($signed(ang_r));
      entry.q   = quad;
      entry.one = (req_sample_v == '0);
      entry.p   = msb;
      entry.m   = entry.one ? ONE_Q30 : (31'(wv[23:0]) << (30 - msb));
   end

   assign vld[0]    = req_valid;
   assign itm[0]    = entry;
   assign req_ready = rdy[0];
   assign rdy[NUM_CELLS] = rsp_ready;

   for (genvar s = 0; s < NUM_CELLS; s++) begin : g_cell
      cph_cell #(
         .STAGE(s),
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cosine_exponent(exponent_ff),
         .up_valid(vld[s]),
         .up_item(itm[s]),
         .up_ready(rdy[s]),
         .dn_valid(vld[s+1]),
         .dn_item(itm[s+1]),
         .dn_ready(rdy[s+1])
      );
   end

   assign rsp_valid = vld[NUM_CELLS];
   assign rsp_dir_u = itm[NUM_CELLS].du;
   assign rsp_dir_v = itm[NUM_CELLS].dv;
   assign rsp_dir_w = itm[NUM_CELLS].w15;

   a_pole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && itm[NUM_CELLS].one |->
         rsp_dir_u == 16'sd0 && rsp_dir_v == 16'sd0 && rsp_dir_w == W_MAX)
      else $error("pole request gave a tilted direction");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("row stalled while the result side was free");

   a_ct: assert property (@(posedge clock) disable iff (reset)
      vld[ST_SQUARE] |-> itm[ST_SQUARE].ct <= ONE_Q30)
      else $error("cos theta above one");

   a_st: assert property (@(posedge clock) disable iff (reset)
      vld[ST_MULU] |-> itm[ST_MULU].res <= 62'(ONE_Q30))
      else $error("sin theta above one");

endmodule

>>> dv/cosine_power_hemisphere_map_tb.sv
// Testbench for the cosine-power hemisphere mapper: bit-exact prediction, random traffic.
module cosine_power_hemisphere_map_tb import cph_pkg::*; ();

   localparam int SB = 16;
   localparam int LATENCY = 115;

   typedef struct {
      logic [15:0] u;
      logic [15:0] v;
   } sample_type;

   typedef struct {
      logic signed [15:0] du;
      logic signed [15:0] dv;
      logic [14:0]        dw;
   } dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_sample_u = '0;
   logic [15:0] req_sample_v = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_dir_u;
   logic signed [15:0] rsp_dir_v;
   logic [14:0] rsp_dir_w;

   cosine_power_hemisphere_map #(.SAMPLE_BITS(SB)) i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_u(req_sample_u), .req_sample_v(req_sample_v),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_dir_u(rsp_dir_u), .rsp_dir_v(rsp_dir_v), .rsp_dir_w(rsp_dir_w)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sample_type pending_samples[$];
   dir_type    expected_dirs[$];
   logic [15:0] exponent_q88 = '0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   bit  long_stall_go = 1'b0;
   int  errors = 0;
   int  dirs_checked = 0;

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else
            res = res >> 1;
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint asr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic [63:0] polar_cos(input logic [63:0] v, input logic [63:0] e);
      logic [63:0] full, w, m, frac, nl, d, dd, f, r, c, n;
      int p;
      full = 64'd1 << SB;
      w = full - v;
      frac = 0;
      p = 0;
      if (w >= full) return 64'd1 << 30;
      while ((w >> (p + 1)) != 0) p++;
      m = w << (30 - p);
      for (int k = 0; k < 24; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      nl = ((64'(SB - p)) << 24) - frac;
      d = e + 256;
      dd = (nl * 256 + d / 2) / d;
      f = dd & ((64'd1 << 24) - 1);
      n = dd >> 24;
      r = 64'd1 << 30;
      c = 64'd1 << 29;
      for (int k = 1; k <= 24; k++) begin
         c = isqrt(c << 30);
         if ((f >> (24 - k)) & 1) r = (r * c + (64'd1 << 29)) >> 30;
      end
      if (n >= 31) return 0;
      return r >> n;
   endfunction

   function automatic logic [15:0] to_q15(input logic [63:0] st, input longint trig);
      logic [63:0] mag, r;
      mag = trig < 0 ? 64'(-trig) : 64'(trig);
      r = (st * mag + (64'd1 << 44)) >> 45;
      if (trig < 0) return r > 32768 ? 16'h8000 : 16'(-longint'(r));
      return r > 32767 ? 16'h7FFF : r[15:0];
   endfunction

   function automatic dir_type map_direction(input sample_type s, input logic [15:0] e);
      dir_type o;
      logic [31:0] a, ru, q;
      longint z, x, y, dx, dy, co, si;
      logic [63:0] ct, st, w;
      a = {s.u, 16'h0};
      q = ((a + 32'h2000_0000) >> 30) & 3;
      ru = a - (q << 30);
      z = longint'($signed(ru));
      x = 64'h26DD3B6A;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
         end
      end
      case (q)
         0: begin co = x; si = y; end
         1: begin co = -y; si = x; end
         2: begin co = -x; si = -y; end
         default: begin co = y; si = -x; end
      endcase
      ct = polar_cos({48'h0, s.v}, {48'h0, e});
      if (ct > (64'd1 << 30)) ct = 64'd1 << 30;
      st = isqrt((64'd1 << 60) - ct * ct);
      w = (ct + 16384) >> 15;
      if (w > 32767) w = 32767;
      o.du = to_q15(st, co);
      o.dv = to_q15(st, si);
      o.dw = w[14:0];
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, dirs_checked);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      sample_type s;
      if (!reset) begin
         if (req_valid && req_ready) begin
            s = pending_samples.pop_front();
            expected_dirs.insert(expected_dirs.size(), map_direction(s, exponent_q88));
         end
         if ((!req_valid || req_ready) && pending_samples.size() != 0
             && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_sample_u <= pending_samples[0].u;
            req_sample_v <= pending_samples[0].v;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   initial begin
      wait (long_stall_go);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dirs.size() == 0) begin
               report_mismatch("unexpected result dir_u", rsp_dir_u, 0);
            end else begin
               dir_type e;
               e = expected_dirs.pop_front();
               if (rsp_dir_u !== e.du) report_mismatch("dir_u", rsp_dir_u, e.du);
               if (rsp_dir_v !== e.dv) report_mismatch("dir_v", rsp_dir_v, e.dv);
               if (rsp_dir_w !== e.dw) report_mismatch("dir_w", rsp_dir_w, e.dw);
            end
            dirs_checked++;
         end
         if (hold_off)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   task automatic add_sample(input logic [15:0] u, input logic [15:0] v);
      sample_type s;
      s.u = u;
      s.v = v;
      pending_samples.insert(pending_samples.size(), s);
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || req_valid || expected_dirs.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_exponent(input logic [15:0] e);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= e;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      exponent_q88 = e;
   endtask

   task automatic random_samples(input int n);
      logic [15:0] v;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(5))
            0: v = 16'($urandom_range(3));
            1: v = 16'hFFFF - 16'($urandom_range(3));
            default: v = 16'($urandom);
         endcase
         add_sample(16'($urandom), v);
      end
   endtask

   initial begin
      logic [15:0] exps[6];
      exps = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0001, 16'h0A80, 16'h8000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: quadrant edges, v extremes, single-bit patterns
      add_sample(16'h0000, 16'h0000);
      add_sample(16'hFFFF, 16'hFFFF);
      add_sample(16'h4000, 16'h8000);
      add_sample(16'h8000, 16'h0001);
      add_sample(16'hC000, 16'hFFFE);
      add_sample(16'h2000, 16'h5555);
      add_sample(16'h6000, 16'hAAAA);
      add_sample(16'hE000, 16'h7FFF);
      add_sample(16'h1FFF, 16'h0000);
      add_sample(16'hA000, 16'hFFFF);
      add_sample(16'h5555, 16'h0100);
      add_sample(16'hAAAA, 16'hFF00);
      drain();

      foreach (exps[k]) begin
         write_exponent(exps[k]);
         send_idle_pct  = (k % 4 == 1) ? 56 : (k % 4 == 3) ? 37 : 0;
         recv_stall_pct = (k % 4 == 2) ? 56 : (k % 4 == 3) ? 37 : 0;
         add_sample(16'h0000, 16'hFFFF);
         add_sample(16'h8000, 16'h0000);
         random_samples(290);
         if (k == 2) begin
            // receiver holds off while the sender keeps going
            long_stall_go = 1'b1;
         end
         drain();
      end
      write_exponent(16'($urandom));
      random_samples(40);
      drain();

      $display("covered %0d results over %0d exponent settings with idle and stall phases",
               dirs_checked, $size(exps) + 1);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule
